// ===== hw/rtl/drtl_pkg.sv =====
// Shared types and constants of the DFA range transition lookup engine.
// Depends on nothing; the other files refer to it by scoped names or import it.

package drtl_pkg;

    localparam int NUM_STATES  = 256;
    localparam int NUM_RANGES  = 1024;
    localparam int SYMBOL_BITS = 8;

    localparam int STATE_W  = 8;                          // state numbers and targets
    localparam int INDEX_W  = 10;                         // entry_index field
    localparam int RIDX_W   = $clog2(NUM_RANGES);         // range store address
    localparam int OFS_W    = $clog2(NUM_RANGES + 1);     // offsets, counts, run positions
    localparam int OFF_AW   = $clog2(NUM_STATES + 1);     // offset store address
    localparam int FUNC_W   = 2;
    localparam int TDATA_W  = 64;
    localparam int TDATA_PAD = TDATA_W - (INDEX_W + 3 * SYMBOL_BITS - SYMBOL_BITS + STATE_W
                                          + OFS_W + STATE_W + SYMBOL_BITS);

    // Function codes carried in the input tuser
    localparam logic [FUNC_W-1:0] FUNC_LOAD_RANGE  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_OFFSET = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP      = 2'd2;

    // Input word, first field in the lowest bits
    typedef struct packed {
        logic [TDATA_PAD-1:0]   reserved;
        logic [SYMBOL_BITS-1:0] symbol;
        logic [STATE_W-1:0]     current_state;
        logic [OFS_W-1:0]       start_offset;
        logic [STATE_W-1:0]     range_target;
        logic [SYMBOL_BITS-1:0] range_high;
        logic [SYMBOL_BITS-1:0] range_low;
        logic [INDEX_W-1:0]     entry_index;
    } in_word_t;

    typedef struct packed {
        logic [SYMBOL_BITS-1:0] low;
        logic [SYMBOL_BITS-1:0] high;
        logic [STATE_W-1:0]     target;
    } range_entry_t;

    // Which run position the range store read uses
    typedef enum logic [1:0] {
        RSEL_PROBE_CUR,
        RSEL_PROBE_NEXT,
        RSEL_AT_IDX,
        RSEL_AT_PREV
    } rng_sel_t;

    typedef struct packed {
        logic     wr_range;
        logic     wr_off;
        logic     start;
        logic     rd_off_end;
        logic     cap_first;
        logic     cap_last;
        logic     rng_rd;
        rng_sel_t rng_sel;
        logic     step;
        logic     set_res;
        logic     res_hit;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic state_bad;
        logic run_empty;
        logic n_zero;
        logic n_next_zero;
        logic idx_lt_len;
        logic idx_zero;
        logic sym_ge_low;
        logic sym_le_high;
        logic out_free;
    } stat_t;

endpackage

// ===== hw/rtl/drtl_datapath.sv =====
// Datapath of the DFA range transition lookup: range and offset stores,
// binary search registers and the output word register. Uses drtl_pkg.

module drtl_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  drtl_pkg::in_word_t    in_word,
    input  drtl_pkg::cmd_t        cmd,
    output drtl_pkg::stat_t       stat,
    input  logic                  m_axis_tready,
    output logic                  m_axis_tvalid,
    output logic [7:0]            m_axis_tdata,
    output logic [0:0]            m_axis_tuser
);

    drtl_pkg::range_entry_t range_mem [drtl_pkg::NUM_RANGES];
    logic [drtl_pkg::OFS_W-1:0] off_mem [drtl_pkg::NUM_STATES + 1];

    drtl_pkg::range_entry_t rng_rd_reg;
    logic [drtl_pkg::OFS_W-1:0] off_rd_reg;

    logic [drtl_pkg::STATE_W-1:0]     cur_state_reg;
    logic [drtl_pkg::SYMBOL_BITS-1:0] sym_reg;
    logic [drtl_pkg::OFS_W-1:0]       first_reg;
    logic [drtl_pkg::OFS_W-1:0]       len_reg;
    logic [drtl_pkg::OFS_W-1:0]       lo_reg;
    logic [drtl_pkg::OFS_W-1:0]       n_reg;
    logic [drtl_pkg::OFS_W-1:0]       mid_reg;
    logic                             res_hit_reg;
    logic [drtl_pkg::STATE_W-1:0]     res_target_reg;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [drtl_pkg::STATE_W-1:0]     out_state_reg;
    logic                             out_sink_reg;

    logic [drtl_pkg::OFS_W-1:0]  off_clamped;
    logic [drtl_pkg::OFS_W-1:0]  half;
    logic                        probe_below;
    logic [drtl_pkg::OFS_W-1:0]  lo_next;
    logic [drtl_pkg::OFS_W-1:0]  n_next;
    logic [drtl_pkg::OFS_W-1:0]  rng_rel;
    logic [drtl_pkg::OFS_W-1:0]  rng_abs;
    logic [drtl_pkg::RIDX_W-1:0] rng_addr;
    logic [drtl_pkg::OFF_AW-1:0] off_raddr;
    logic                        range_wr_ok;
    logic                        off_wr_ok;

    // Offsets beyond the range store saturate at its depth
    assign off_clamped = (off_rd_reg > drtl_pkg::OFS_W'(drtl_pkg::NUM_RANGES))
                       ? drtl_pkg::OFS_W'(drtl_pkg::NUM_RANGES) : off_rd_reg;

    // One halving step, driven by the probe read of the previous cycle
    assign half        = n_reg >> 1;
    assign probe_below = rng_rd_reg.low < sym_reg;
    assign lo_next     = probe_below ? mid_reg + drtl_pkg::OFS_W'(1) : lo_reg;
    assign n_next      = probe_below ? n_reg - half - drtl_pkg::OFS_W'(1) : half;

    always_comb
    begin
        unique case (cmd.rng_sel)
            drtl_pkg::RSEL_PROBE_CUR:  rng_rel = lo_reg + half;
            drtl_pkg::RSEL_PROBE_NEXT: rng_rel = lo_next + (n_next >> 1);
            drtl_pkg::RSEL_AT_IDX:     rng_rel = lo_reg;
            drtl_pkg::RSEL_AT_PREV:    rng_rel = lo_reg - drtl_pkg::OFS_W'(1);
            default:                   rng_rel = lo_reg;
        endcase
    end

    assign rng_abs  = first_reg + rng_rel;
    assign rng_addr = rng_abs[drtl_pkg::RIDX_W-1:0];

    assign off_raddr = cmd.start
                     ? drtl_pkg::OFF_AW'(in_word.current_state)
                     : drtl_pkg::OFF_AW'(32'(cur_state_reg) + 1);

    assign range_wr_ok = 32'(in_word.entry_index) < drtl_pkg::NUM_RANGES;
    assign off_wr_ok   = 32'(in_word.entry_index) <= drtl_pkg::NUM_STATES;

    // Stores and their registered read ports
    always_ff @(posedge clk)
    begin
        if (cmd.wr_range && range_wr_ok)
        begin
            range_mem[drtl_pkg::RIDX_W'(in_word.entry_index)] <=
                '{low: in_word.range_low, high: in_word.range_high,
                  target: in_word.range_target};
        end
        if (cmd.rng_rd)
        begin
            rng_rd_reg <= range_mem[rng_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_off && off_wr_ok)
        begin
            off_mem[drtl_pkg::OFF_AW'(in_word.entry_index)] <= in_word.start_offset;
        end
        if (cmd.start || cmd.rd_off_end)
        begin
            off_rd_reg <= off_mem[off_raddr];
        end
    end

    // Search registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            cur_state_reg <= in_word.current_state;
            sym_reg       <= in_word.symbol;
        end
        if (cmd.cap_first)
        begin
            first_reg <= off_clamped;
        end
        if (cmd.cap_last)
        begin
            len_reg <= off_clamped - first_reg;
            n_reg   <= off_clamped - first_reg;
            lo_reg  <= '0;
        end
        else if (cmd.step)
        begin
            lo_reg <= lo_next;
            n_reg  <= n_next;
        end
        if (cmd.rng_rd)
        begin
            mid_reg <= rng_rel;
        end
        if (cmd.set_res)
        begin
            res_hit_reg    <= cmd.res_hit;
            res_target_reg <= rng_rd_reg.target;
        end
        if (cmd.out_load)
        begin
            out_state_reg <= res_hit_reg ? res_target_reg : '0;
            out_sink_reg  <= !res_hit_reg;
        end
    end

    // Output word register: load a result, drop it once taken
    always_comb
    begin
        priority if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_state_reg;
    assign m_axis_tuser[0] = out_sink_reg;

    assign stat.state_bad   = 32'(in_word.current_state) >= drtl_pkg::NUM_STATES;
    assign stat.run_empty   = off_clamped < first_reg;
    assign stat.n_zero      = n_reg == '0;
    assign stat.n_next_zero = n_next == '0;
    assign stat.idx_lt_len  = lo_reg < len_reg;
    assign stat.idx_zero    = lo_reg == '0;
    assign stat.sym_ge_low  = sym_reg >= rng_rd_reg.low;
    assign stat.sym_le_high = sym_reg <= rng_rd_reg.high;
    assign stat.out_free    = !out_valid_reg || m_axis_tready;

endmodule

// ===== hw/rtl/drtl_ctrl.sv =====
// Controller of the DFA range transition lookup: sequences loads, offset reads,
// binary search probes and result hand-off. Uses drtl_pkg.

module drtl_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [drtl_pkg::FUNC_W-1:0]  s_axis_tuser,
    input  drtl_pkg::stat_t              stat,
    output drtl_pkg::cmd_t               cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_OFF0,
        S_OFF1,
        S_ISSUE,
        S_SEARCH,
        S_FIN_A,
        S_FIN_B,
        S_FIN_C,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_axis_tready = state_reg == S_IDLE;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (s_axis_tuser)
                        drtl_pkg::FUNC_LOAD_RANGE:  cmd.wr_range = 1'b1;
                        drtl_pkg::FUNC_LOAD_OFFSET: cmd.wr_off   = 1'b1;
                        drtl_pkg::FUNC_LOOKUP:
                        begin
                            if (stat.state_bad)
                            begin
                                cmd.set_res = 1'b1;
                                state_next  = S_RESULT;
                            end
                            else
                            begin
                                cmd.start  = 1'b1;
                                state_next = S_OFF0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_OFF0:
            begin
                cmd.cap_first  = 1'b1;
                cmd.rd_off_end = 1'b1;
                state_next     = S_OFF1;
            end
            S_OFF1:
            begin
                cmd.cap_last = 1'b1;
                if (stat.run_empty)
                begin
                    cmd.set_res = 1'b1;
                    state_next  = S_RESULT;
                end
                else
                begin
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                if (stat.n_zero)
                begin
                    state_next = S_FIN_A;
                end
                else
                begin
                    cmd.rng_rd  = 1'b1;
                    cmd.rng_sel = drtl_pkg::RSEL_PROBE_CUR;
                    state_next  = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                cmd.step = 1'b1;
                if (stat.n_next_zero)
                begin
                    state_next = S_FIN_A;
                end
                else
                begin
                    cmd.rng_rd  = 1'b1;
                    cmd.rng_sel = drtl_pkg::RSEL_PROBE_NEXT;
                end
            end
            S_FIN_A:
            begin
                priority if (stat.idx_lt_len)
                begin
                    cmd.rng_rd  = 1'b1;
                    cmd.rng_sel = drtl_pkg::RSEL_AT_IDX;
                    state_next  = S_FIN_B;
                end
                else if (stat.idx_zero)
                begin
                    cmd.set_res = 1'b1;
                    state_next  = S_RESULT;
                end
                else
                begin
                    cmd.rng_rd  = 1'b1;
                    cmd.rng_sel = drtl_pkg::RSEL_AT_PREV;
                    state_next  = S_FIN_C;
                end
            end
            S_FIN_B:
            begin
                priority if (stat.sym_ge_low)
                begin
                    cmd.set_res = 1'b1;
                    cmd.res_hit = 1'b1;
                    state_next  = S_RESULT;
                end
                else if (stat.idx_zero)
                begin
                    cmd.set_res = 1'b1;
                    state_next  = S_RESULT;
                end
                else
                begin
                    cmd.rng_rd  = 1'b1;
                    cmd.rng_sel = drtl_pkg::RSEL_AT_PREV;
                    state_next  = S_FIN_C;
                end
            end
            S_FIN_C:
            begin
                cmd.set_res = 1'b1;
                cmd.res_hit = stat.sym_le_high;
                state_next  = S_RESULT;
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/dfa_range_transition_lookup_top.sv =====
// Top level of the DFA range transition lookup engine.
// Depends on drtl_pkg, drtl_ctrl and drtl_datapath.
//
// Usage:
//   Input stream (s_axis_*): tuser selects the function of the word: load a
//   range entry, load a state start offset, or look up a transition. Loads
//   write the stores and produce no output word; a lookup produces exactly one.
//   Unused function codes are accepted and dropped.
//   Output stream (m_axis_*): tdata holds the next state (zero on a miss),
//   tuser is set when no range of the state holds the symbol.
// Sequence:
//   A lookup reads both offsets of the state, then probes the single range
//   store read port once per halving step, then checks the entry at the found
//   position and, if needed, the one before it; a reversed or empty run skips the probes.
//   One word is in flight; tready is high only between words.
// Stall: a finished result waits in the output register; the engine accepts
//   the next word meanwhile and stalls only when a second result is ready
//   while the first has not been taken.
// Reset: clears the controller and the output valid; store contents are
//   undefined until loaded, so load offsets and ranges before any lookup.

module dfa_range_transition_lookup_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // entry_index[9:0], range_low[17:10], range_high[25:18], range_target[33:26],
    // start_offset[44:34], current_state[52:45], symbol[60:53], zero[63:61]
    input  logic [63:0] s_axis_tdata,
    // func[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // next_state[7:0]
    output logic [7:0]  m_axis_tdata,
    // is_sink[0]
    output logic [0:0]  m_axis_tuser
);

    drtl_pkg::in_word_t in_word;
    drtl_pkg::cmd_t     cmd;
    drtl_pkg::stat_t    stat;

    // Unpack the input word into its fields
    assign in_word = drtl_pkg::in_word_t'(s_axis_tdata);

    drtl_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .stat          (stat),
        .cmd           (cmd)
    );

    drtl_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_word       (in_word),
        .cmd           (cmd),
        .stat          (stat),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== bench/dfa_range_transition_lookup_top_test.sv =====
// Self-checking bench for the DFA range transition lookup engine.
// Depends on drtl_pkg and dfa_range_transition_lookup_top; runs directed words
// and then random table builds, checking each lookup against a predictor.

module dfa_range_transition_lookup_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import drtl_pkg::*;

    // Code that the engine accepts and drops
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int NUM_DIRECTED  = 25;
    localparam int RANDOM_WORDS  = 1150;
    localparam int LONG_HOLD     = 400;   // one long receiver hold-off, in cycles
    localparam int DRAIN_CYCLES  = 40;    // worst lookup is well under this
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [7:0] next_state;
        logic       is_sink;
    } transition_t;

    // One expected output word with the lookup that caused it, for reports
    typedef struct packed {
        transition_t r;
        logic [7:0]  current_state;
        logic [7:0]  symbol;
    } expected_word_t;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [INDEX_W-1:0] idx;
        logic [7:0]         lo;
        logic [7:0]         hi;
        logic [7:0]         tgt;
        logic [OFS_W-1:0]   ofs;
        logic [7:0]         st;
        logic [7:0]         sym;
        logic               typed;      // expectation typed in below
        logic [7:0]         exp_next;
        logic               exp_sink;
    } directed_row_t;

    typedef enum {
        RX_ALWAYS,
        RX_HALF,
        RX_SPARSE,
        RX_BURSTY
    } rx_mode_t;

    typedef enum {
        NOISE_UNUSED_FUNC,
        NOISE_OFFSET_IGNORED,
        NOISE_OFFSET_ANY,
        NOISE_RANGE_ANY,
        NOISE_LOOKUP
    } noise_kind_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    dfa_range_transition_lookup_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Directed words. Store entries are written before any lookup reads them.
    // func, idx, lo, hi, tgt, ofs, st, sym, typed, exp_next, exp_sink
    directed_row_t directed_rows [NUM_DIRECTED] = '{
        // state 0 owns entries 0..2; the last one has its low above its high
        '{FUNC_LOAD_RANGE,  10'd0,   8'h10, 8'h1F, 8'h05, 11'd0,    8'd0,   8'h00, 1'b0, 8'h00, 1'b0},
        '{FUNC_LOAD_RANGE,  10'd1,   8'h40, 8'h7F, 8'hFF, 11'd0,    8'd0,   8'h00, 1'b0, 8'h00, 1'b0},
        '{FUNC_LOAD_RANGE,  10'd2,   8'hFF, 8'h00, 8'hA5, 11'd0,    8'd0,   8'h00, 1'b0, 8'h00, 1'b0},
        '{FUNC_LOAD_OFFSET, 10'd0,   8'h00, 8'h00, 8'h00, 11'd0,    8'd0,   8'h00, 1'b0, 8'h00, 1'b0},
        '{FUNC_LOAD_OFFSET, 10'd1,   8'h00, 8'h00, 8'h00, 11'd3,    8'd0,   8'h00, 1'b0, 8'h00, 1'b0},
        // state 1 has an empty run, state 2 has its end below its start
        '{FUNC_LOAD_OFFSET, 10'd2,   8'h00, 8'h00, 8'h00, 11'd3,    8'd0,   8'h00, 1'b0, 8'h00, 1'b0},
        '{FUNC_LOAD_OFFSET, 10'd3,   8'h00, 8'h00, 8'h00, 11'd0,    8'd0,   8'h00, 1'b0, 8'h00, 1'b0},
        '{FUNC_LOOKUP,      10'd0,   8'h00, 8'h00, 8'h00, 11'd0,    8'd0,   8'h10, 1'b1, 8'h05, 1'b0},
        '{FUNC_LOOKUP,      10'd0,   8'h00, 8'h00, 8'h00, 11'd0,    8'd0,   8'h1F, 1'b0, 8'h00, 1'b0},
        '{FUNC_LOOKUP,      10'd0,   8'h00, 8'h00, 8'h00, 11'd0,    8'd0,   8'h20, 1'b1, 8'h00, 1'b1},
        '{FUNC_LOOKUP,      10'd0,   8'h00, 8'h00, 8'h00, 11'd0,    8'd0,   8'h00, 1'b1, 8'h00, 1'b1},
        // symbol on a low bound hits without looking at the high bound
        '{FUNC_LOOKUP,      10'd0,   8'h00, 8'h00, 8'h00, 11'd0,    8'd0,   8'hFF, 1'b1, 8'hA5, 1'b0},
        '{FUNC_LOOKUP,      10'd0,   8'h00, 8'h00, 8'h00, 11'd0,    8'd0,   8'h7F, 1'b0, 8'h00, 1'b0},
        '{FUNC_LOOKUP,      10'd0,   8'h00, 8'h00, 8'h00, 11'd0,    8'd1,   8'h55, 1'b1, 8'h00, 1'b1},
        '{FUNC_LOOKUP,      10'd0,   8'h00, 8'h00, 8'h00, 11'd0,    8'd2,   8'h10, 1'b1, 8'h00, 1'b1},
        '{FUNC_UNUSED,      10'h3FF, 8'hFF, 8'hFF, 8'hFF, 11'h7FF,  8'hFF,  8'hFF, 1'b0, 8'h00, 1'b0},
        // offset loads past the store; 513 would alias onto state 1 in 9 bits
        '{FUNC_LOAD_OFFSET, 10'd257, 8'h00, 8'h00, 8'h00, 11'd0,    8'd0,   8'h00, 1'b0, 8'h00, 1'b0},
        '{FUNC_LOAD_OFFSET, 10'd513, 8'h00, 8'h00, 8'h00, 11'd0,    8'd0,   8'h00, 1'b0, 8'h00, 1'b0},
        '{FUNC_LOOKUP,      10'd0,   8'h00, 8'h00, 8'h00, 11'd0,    8'd0,   8'h12, 1'b1, 8'h05, 1'b0},
        // offsets above the range store saturate, leaving state 4 empty
        '{FUNC_LOAD_OFFSET, 10'd4,   8'h00, 8'h00, 8'h00, 11'h7FF,  8'd0,   8'h00, 1'b0, 8'h00, 1'b0},
        '{FUNC_LOAD_OFFSET, 10'd5,   8'h00, 8'h00, 8'h00, 11'd1024, 8'd0,   8'h00, 1'b0, 8'h00, 1'b0},
        '{FUNC_LOOKUP,      10'd0,   8'h00, 8'h00, 8'h00, 11'd0,    8'd4,   8'h00, 1'b1, 8'h00, 1'b1},
        '{FUNC_LOAD_OFFSET, 10'd255, 8'h00, 8'h00, 8'h00, 11'd1024, 8'd0,   8'h00, 1'b0, 8'h00, 1'b0},
        '{FUNC_LOAD_OFFSET, 10'd256, 8'h00, 8'h00, 8'h00, 11'd1023, 8'd0,   8'h00, 1'b0, 8'h00, 1'b0},
        '{FUNC_LOOKUP,      10'd0,   8'h00, 8'h00, 8'h00, 11'd0,    8'd255, 8'hFF, 1'b1, 8'h00, 1'b1}
    };

    // Predictor copy of the stores, written as words are accepted
    logic [7:0]       low_mem  [NUM_RANGES];
    logic [7:0]       high_mem [NUM_RANGES];
    logic [7:0]       tgt_mem  [NUM_RANGES];
    logic [OFS_W-1:0] ofs_mem  [NUM_STATES+1];

    // Generator view of what has been sent, so no lookup reads an unwritten entry
    logic [OFS_W-1:0] gen_ofs    [NUM_STATES+1];
    bit               gen_ofs_wr [NUM_STATES+1];
    bit               gen_rng_wr [NUM_RANGES];

    expected_word_t expected_transitions[$];

    // Side channel that travels with the input word: typed-in expectation
    logic        drv_typed;
    transition_t drv_exp;

    int burst_left      = 0;
    int words_effective = 0;
    int mismatches      = 0;
    int results_seen    = 0;
    int results_sink    = 0;
    int n_range_loads   = 0;
    int n_offset_loads  = 0;
    int n_lookups       = 0;
    int n_dropped       = 0;
    int hold_cycles     = 0;
    bit hold_request    = 0;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int clamp_ofs(input logic [OFS_W-1:0] v);
        return (v > NUM_RANGES) ? NUM_RANGES : int'(v);
    endfunction

    // Next state of a lookup: search the state's run for the first low bound
    // not below the symbol, then try that entry and the one just before it.
    function automatic transition_t predict_transition(input logic [7:0] st,
                                                       input logic [7:0] sym);
        transition_t r;
        int          first, last, len, lo, n, half, mid;
        r.next_state = '0;
        r.is_sink    = 1'b1;
        if (int'(st) >= NUM_STATES)
            return r;
        first = clamp_ofs(ofs_mem[st]);
        last  = clamp_ofs(ofs_mem[int'(st) + 1]);
        if (last < first)
            return r;
        len = last - first;
        lo  = 0;
        n   = len;
        while (n > 0) begin
            half = n / 2;
            mid  = lo + half;
            if (low_mem[first + mid] < sym) begin
                lo = mid + 1;
                n  = n - half - 1;
            end
            else begin
                n = half;
            end
        end
        if (lo < len && sym >= low_mem[first + lo]) begin
            r.next_state = tgt_mem[first + lo];
            r.is_sink    = 1'b0;
        end
        else if (lo > 0 && sym <= high_mem[first + lo - 1]) begin
            r.next_state = tgt_mem[first + lo - 1];
            r.is_sink    = 1'b0;
        end
        return r;
    endfunction

    // A state may be looked up once both offsets and every entry of its run exist
    function automatic bit state_is_readable(input int s);
        int first, last, i;
        if (!gen_ofs_wr[s] || !gen_ofs_wr[s + 1])
            return 1'b0;
        first = clamp_ofs(gen_ofs[s]);
        last  = clamp_ofs(gen_ofs[s + 1]);
        for (i = first; i < last; i++)
            if (!gen_rng_wr[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic in_word_t random_word();
        in_word_t w;
        w               = '0;
        w.entry_index   = INDEX_W'($urandom);
        w.range_low     = 8'($urandom);
        w.range_high    = 8'($urandom);
        w.range_target  = 8'($urandom);
        w.start_offset  = OFS_W'($urandom);
        w.current_state = 8'($urandom);
        w.symbol        = 8'($urandom);
        return w;
    endfunction

    // Offer one word and hold it until accepted. Bursts of random length are
    // separated by random gaps with tvalid low.
    task automatic send_word(input logic [FUNC_W-1:0] func, input in_word_t w,
                             input logic typed, input transition_t exp_r);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= func;
        drv_typed     <= typed;
        drv_exp       <= exp_r;
        do
            @(posedge clk);
        while (!s_axis_tready);

        if (func == FUNC_LOAD_RANGE) begin
            gen_rng_wr[w.entry_index] = 1'b1;
            words_effective++;
        end
        else if (func == FUNC_LOAD_OFFSET && w.entry_index <= NUM_STATES) begin
            gen_ofs[w.entry_index]    = w.start_offset;
            gen_ofs_wr[w.entry_index] = 1'b1;
            words_effective++;
        end
        else if (func == FUNC_LOOKUP) begin
            words_effective++;
        end
    endtask

    // Build a small automaton: a few consecutive states with contiguous runs,
    // mostly sorted, then look up symbols that mostly lie close to the loaded bounds.
    task automatic load_dfa_table();
        int         num_st, first_st, base, total, pos, n_look, pick, e, i, j;
        int         run_len[$];
        int         run_start[$];
        logic [7:0] lows[$];
        logic [7:0] sess_low[$];
        logic [7:0] sess_high[$];
        logic [7:0] hi_lim;
        logic [7:0] sym;
        bit         unsorted;
        in_word_t   w;
        transition_t none;

        none     = '0;
        num_st   = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
        first_st = $urandom_range(0, NUM_STATES - num_st);
        total    = 0;
        for (i = 0; i < num_st; i++) begin
            run_len.push_back(($urandom_range(0, 14) == 0) ? $urandom_range(30, 120)
                                                           : $urandom_range(0, 6));
            total += run_len[i];
        end
        // now and then pack the table against the top of the range store
        base = ($urandom_range(0, 7) == 0) ? NUM_RANGES - total
                                           : $urandom_range(0, NUM_RANGES - total);
        pos  = base;

        for (i = 0; i < num_st; i++) begin
            run_start.push_back(pos);
            unsorted = ($urandom_range(0, 9) == 0);
            lows.delete();
            for (j = 0; j < run_len[i]; j++)
                lows.push_back(8'($urandom));
            if (!unsorted)
                lows.sort();
            for (j = 0; j < run_len[i]; j++) begin
                hi_lim        = (j + 1 < run_len[i]) ? lows[j + 1] : 8'hFF;
                w             = random_word();
                w.entry_index = INDEX_W'(pos + j);
                w.range_low   = lows[j];
                w.range_high  = (unsorted || $urandom_range(0, 7) == 0)
                                ? 8'($urandom) : 8'($urandom_range(lows[j], hi_lim));
                sess_low.push_back(w.range_low);
                sess_high.push_back(w.range_high);
                send_word(FUNC_LOAD_RANGE, w, 1'b0, none);
            end
            pos += run_len[i];
        end
        run_start.push_back(pos);

        for (i = 0; i <= num_st; i++) begin
            w              = random_word();
            w.entry_index  = INDEX_W'(first_st + i);
            w.start_offset = OFS_W'(run_start[i]);
            send_word(FUNC_LOAD_OFFSET, w, 1'b0, none);
        end

        n_look = $urandom_range(2 * num_st, 2 * num_st + total / 2 + 4);
        if (n_look > 40)
            n_look = 40;
        for (i = 0; i < n_look; i++) begin
            pick = $urandom_range(0, num_st - 1);
            if (!state_is_readable(first_st + pick))
                continue;
            sym = 8'($urandom);
            if (run_len[pick] > 0 && $urandom_range(0, 9) < 7) begin
                e = run_start[pick] - base + $urandom_range(0, run_len[pick] - 1);
                case ($urandom_range(0, 3))
                    0:       sym = sess_low[e];
                    1:       sym = sess_high[e];
                    2:       sym = sess_low[e] - 8'd1;
                    default: sym = sess_high[e] + 8'd1;
                endcase
            end
            w               = random_word();
            w.current_state = 8'(first_st + pick);
            w.symbol        = sym;
            send_word(FUNC_LOOKUP, w, 1'b0, none);
        end
    endtask

    // Stray words between table builds: dropped codes, loads past the stores,
    // offsets that overlap, reverse or saturate, and lookups of any usable state.
    task automatic send_noise_word();
        noise_kind_t kind;
        in_word_t    w;
        transition_t none;
        int          tries, st;
        none = '0;
        w    = random_word();
        kind = noise_kind_t'($urandom_range(0, 4));
        case (kind)
            NOISE_UNUSED_FUNC:
                send_word(FUNC_UNUSED, w, 1'b0, none);
            NOISE_OFFSET_IGNORED: begin
                w.entry_index = INDEX_W'($urandom_range(NUM_STATES + 1, 1023));
                send_word(FUNC_LOAD_OFFSET, w, 1'b0, none);
            end
            NOISE_OFFSET_ANY: begin
                w.entry_index  = INDEX_W'($urandom_range(0, NUM_STATES));
                w.start_offset = ($urandom_range(0, 3) == 0)
                                 ? OFS_W'($urandom_range(NUM_RANGES + 1, 2047))
                                 : OFS_W'($urandom_range(0, NUM_RANGES));
                send_word(FUNC_LOAD_OFFSET, w, 1'b0, none);
            end
            NOISE_RANGE_ANY:
                send_word(FUNC_LOAD_RANGE, w, 1'b0, none);
            default: begin
                st = -1;
                for (tries = 0; tries < 8 && st < 0; tries++) begin
                    w.current_state = 8'($urandom);
                    if (state_is_readable(w.current_state))
                        st = w.current_state;
                end
                send_word((st >= 0) ? FUNC_LOOKUP : FUNC_LOAD_RANGE, w, 1'b0, none);
            end
        endcase
    endtask

    // Receiver: stall on its own pattern, changing mode every segment, and
    // honor one long hold-off so the engine backs up into its input.
    initial begin : receiver
        rx_mode_t mode;
        int       seg, c;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            mode = rx_mode_t'($urandom_range(0, 3));
            seg  = $urandom_range(10, 60);
            for (c = 0; c < seg; c++) begin
                @(posedge clk);
                if (hold_request) begin
                    hold_request = 1'b0;
                    m_axis_tready <= 1'b0;
                    for (hold_cycles = 0; hold_cycles < LONG_HOLD; hold_cycles++)
                        @(posedge clk);
                end
                case (mode)
                    RX_ALWAYS: m_axis_tready <= 1'b1;
                    RX_HALF:   m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_axis_tready <= ((c % 8) < 5);
                endcase
            end
        end
    end

    // Check output words against the oldest expectation, then track the input
    // word accepted at the same edge. Both sides sample pre-edge values.
    always @(posedge clk) begin : scoreboard
        in_word_t       acc;
        expected_word_t exp_w;
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (expected_transitions.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("[%0t] unexpected output word: next_state %0d sink %0d",
                                 $realtime, m_axis_tdata, m_axis_tuser[0]);
                end
                else begin
                    exp_w = expected_transitions.pop_front();
                    if (exp_w.r.is_sink)
                        results_sink++;
                    if (m_axis_tdata !== exp_w.r.next_state ||
                        m_axis_tuser[0] !== exp_w.r.is_sink) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"[%0t] state %0d symbol %02h: expected next_state %0d ",
                                      "sink %0d, got next_state %0d sink %0d"},
                                     $realtime, exp_w.current_state, exp_w.symbol,
                                     exp_w.r.next_state, exp_w.r.is_sink,
                                     m_axis_tdata, m_axis_tuser[0]);
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                acc = s_axis_tdata;
                case (s_axis_tuser)
                    FUNC_LOAD_RANGE: begin
                        low_mem[acc.entry_index]  = acc.range_low;
                        high_mem[acc.entry_index] = acc.range_high;
                        tgt_mem[acc.entry_index]  = acc.range_target;
                        n_range_loads++;
                    end
                    FUNC_LOAD_OFFSET: begin
                        if (acc.entry_index <= NUM_STATES) begin
                            ofs_mem[acc.entry_index] = acc.start_offset;
                            n_offset_loads++;
                        end
                        else begin
                            n_dropped++;
                        end
                    end
                    FUNC_LOOKUP: begin
                        exp_w.current_state = acc.current_state;
                        exp_w.symbol        = acc.symbol;
                        exp_w.r = drv_typed ? drv_exp
                                            : predict_transition(acc.current_state, acc.symbol);
                        expected_transitions.push_back(exp_w);
                        n_lookups++;
                    end
                    default:
                        n_dropped++;
                endcase
            end
        end
    end

    // Main sequence: reset, directed table, random table builds, drain
    initial begin : stimulus
        directed_row_t row;
        in_word_t      w;
        transition_t   tr;
        int            i, start_count, drain_wait;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= FUNC_LOAD_RANGE;
        drv_typed     <= 1'b0;
        drv_exp       <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < NUM_DIRECTED; i++) begin
            row             = directed_rows[i];
            w               = '0;
            w.entry_index   = row.idx;
            w.range_low     = row.lo;
            w.range_high    = row.hi;
            w.range_target  = row.tgt;
            w.start_offset  = row.ofs;
            w.current_state = row.st;
            w.symbol        = row.sym;
            tr.next_state   = row.exp_next;
            tr.is_sink      = row.exp_sink;
            send_word(row.func, w, row.typed, tr);
        end

        // ask for the long hold-off while the table builds keep the input busy
        hold_request = 1'b1;
        start_count  = words_effective;
        while (words_effective - start_count < RANDOM_WORDS) begin
            load_dfa_table();
            repeat ($urandom_range(0, 4)) send_noise_word();
        end
        s_axis_tvalid <= 1'b0;

        drain_wait = 0;
        while (expected_transitions.size() != 0 && drain_wait < 200000) begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_transitions.size() != 0)
            $display("%0d lookups never produced an output word",
                     expected_transitions.size());
        $display("Covered %0d range loads, %0d offset loads, %0d dropped words, %0d lookups",
                 n_range_loads, n_offset_loads, n_dropped, n_lookups);
        $display("Checked %0d output words (%0d sink), one receiver hold of %0d cycles",
                 results_seen, results_sink, hold_cycles);
        if (mismatches == 0 && expected_transitions.size() == 0)
            $display("dfa_range_transition_lookup_top test passed");
        else
            $display("dfa_range_transition_lookup_top test failed");
        $finish;
    end

    // Watchdog, far above the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("dfa_range_transition_lookup_top test failed");
        $finish;
    end

endmodule
